// File: src/bfa_pkg.sv
// Package of the bitmap frame allocator: widths, codes, reset values and the zero-bit encoder.
`default_nettype none
package bfa_pkg;
	localparam int WORD_BITS       = 32;
	localparam int OFF_W           = 5;
	localparam int FRAME_W         = 12;
	localparam int CFG_W           = 13;
	localparam int MAX_FRAMES_DEF  = 4096;
	localparam int FRAME_COUNT_RST = 4096;
	localparam int IN_DATA_W       = 16;
	localparam int OUT_DATA_W      = 16;
	localparam int STATUS_W        = 3;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_HELD      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FREED     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOTHING   = 3'd4;

	// lowest clear bit of a word, meaningful only if one exists
	function automatic logic [OFF_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
		logic [OFF_W-1:0] p;
		p = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				p = OFF_W'(i);
			end
		end
		return p;
	endfunction
endpackage
`default_nettype wire

// File: src/bitmap_frame_allocator.sv
// First-fit bitmap page frame allocator with the bitmap held in a synchronous RAM.
// An allocation scans at most min(frame_count, MAX_FRAMES) / 32 words of the bitmap,
// one RAM word read and priority-encoded per cycle. One item is at work at a time; the
// output register lets the next item enter while a result waits. After reset the RAM is
// cleared one word a cycle, all ceil(MAX_FRAMES / 32) words (128 by default), s_tready low.
`default_nettype none
module bitmap_frame_allocator #(
	parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [bfa_pkg::CFG_W-1:0]        cfg_wdata,   // frame_count
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// [11:0] frame_in, [12] is_kernel, [13] is_writable
	input  wire logic [bfa_pkg::IN_DATA_W-1:0]    s_tdata,
	input  wire logic                             s_tuser,     // opcode
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// [11:0] frame_out, [12] present, [13] writable, [14] user_page
	output logic [bfa_pkg::OUT_DATA_W-1:0]        m_tdata,
	output logic [bfa_pkg::STATUS_W-1:0]          m_tuser      // status
);
	localparam int WB        = bfa_pkg::WORD_BITS;
	localparam int OW        = bfa_pkg::OFF_W;
	localparam int FW        = bfa_pkg::FRAME_W;
	localparam int NUM_WORDS = (MAX_FRAMES + WB - 1) / WB;
	localparam int WIDX      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int CW        = ($clog2(MAX_FRAMES + 1) > bfa_pkg::CFG_W) ?
	                           $clog2(MAX_FRAMES + 1) : bfa_pkg::CFG_W;

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_FREE, S_EMIT} state_t;

	state_t                        state_q;
	logic [WIDX-1:0]               clr_idx_q;
	logic [WIDX-1:0]               scan_idx_q;
	logic [WIDX-1:0]               fr_word_q;
	logic [OW-1:0]                 fr_off_q;
	logic                          fr_ok_q;
	logic                          kern_q;
	logic                          wr_q;
	logic [bfa_pkg::CFG_W-1:0]     frame_count_q;
	logic [bfa_pkg::STATUS_W-1:0]  res_status_q;
	logic [FW-1:0]                 res_frame_q;
	logic [2:0]                    res_flags_q;
	logic                          m_tvalid_q;
	logic [bfa_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic [bfa_pkg::STATUS_W-1:0]  m_tuser_q;

	logic [WB-1:0]                 mem [NUM_WORDS];
	logic [WB-1:0]                 rd_q;
	logic [WIDX-1:0]               mem_ra;
	logic [WIDX-1:0]               mem_wa;
	logic [WB-1:0]                 mem_wd;
	logic                          mem_we;

	logic [CW-1:0]                 fc_ext;
	logic [CW-1:0]                 limit_c;
	logic [CW-1:0]                 words_c;
	logic [CW-1:0]                 frame_ext;
	logic [WIDX-1:0]               in_word;
	logic                          in_ok;
	logic [FW-1:0]                 frame_in;
	logic                          accept;
	logic                          word_full;
	logic [OW-1:0]                 zpos;
	logic                          last_word;
	logic [WIDX+OW-1:0]            new_frame;
	logic                          emit_go;

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	assign frame_in  = s_tdata[FW-1:0];
	assign fc_ext    = CW'(frame_count_q);
	assign limit_c   = (fc_ext < CW'(MAX_FRAMES)) ? fc_ext : CW'(MAX_FRAMES);
	assign words_c   = limit_c >> OW;
	assign frame_ext = CW'(frame_in);
	assign in_word   = frame_ext[OW +: WIDX];
	assign in_ok     = frame_ext < CW'(MAX_FRAMES);
	assign word_full = &rd_q;
	assign zpos      = bfa_pkg::first_zero(rd_q);
	assign last_word = (CW'(scan_idx_q) + CW'(1)) == words_c;
	assign new_frame = {scan_idx_q, zpos};
	assign emit_go   = (state_q == S_EMIT) && (!m_tvalid_q || m_tready);

	always_comb begin
		mem_ra = '0;
		mem_we = 1'b0;
		mem_wa = scan_idx_q;
		mem_wd = rd_q | (WB'(1) << zpos);
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_idx_q;
				mem_wd = '0;
			end
			S_IDLE: begin
				mem_ra = (s_tuser == bfa_pkg::OP_FREE) ? in_word : '0;
			end
			S_SCAN: begin
				mem_ra = scan_idx_q + WIDX'(1);
				mem_we = !word_full;
			end
			S_FREE: begin
				mem_we = fr_ok_q;
				mem_wa = fr_word_q;
				mem_wd = rd_q & ~(WB'(1) << fr_off_q);
			end
			default: begin
				mem_ra = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_idx_q     <= '0;
			frame_count_q <= bfa_pkg::CFG_W'(bfa_pkg::FRAME_COUNT_RST);
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				frame_count_q <= cfg_wdata;
			end
			if (emit_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + WIDX'(1);
					if (clr_idx_q == WIDX'(NUM_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						kern_q      <= s_tdata[FW];
						wr_q        <= s_tdata[FW+1];
						fr_word_q   <= in_word;
						fr_off_q    <= frame_in[OW-1:0];
						fr_ok_q     <= in_ok;
						scan_idx_q  <= '0;
						res_frame_q <= (s_tuser == bfa_pkg::OP_FREE) ? '0 : frame_in;
						res_flags_q <= 3'b000;
						if (s_tuser == bfa_pkg::OP_ALLOC) begin
							if (frame_in != '0) begin
								res_status_q <= bfa_pkg::ST_HELD;
								state_q      <= S_EMIT;
							end else if (words_c == '0) begin
								res_status_q <= bfa_pkg::ST_FULL;
								state_q      <= S_EMIT;
							end else begin
								state_q <= S_SCAN;
							end
						end else if (frame_in == '0) begin
							res_status_q <= bfa_pkg::ST_NOTHING;
							state_q      <= S_EMIT;
						end else begin
							res_status_q <= bfa_pkg::ST_FREED;
							state_q      <= S_FREE;
						end
					end
				end
				S_SCAN: begin
					if (!word_full) begin
						res_status_q <= bfa_pkg::ST_ALLOCATED;
						res_frame_q  <= FW'(new_frame);
						res_flags_q  <= {!kern_q, wr_q, 1'b1};
						state_q      <= S_EMIT;
					end else if (last_word) begin
						res_status_q <= bfa_pkg::ST_FULL;
						state_q      <= S_EMIT;
					end else begin
						scan_idx_q <= scan_idx_q + WIDX'(1);
					end
				end
				S_FREE: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						m_tuser_q  <= res_status_q;
						m_tdata_q  <= bfa_pkg::OUT_DATA_W'({res_flags_q, res_frame_q});
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("item accepted while another is at work");
	a_flags_only_on_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != bfa_pkg::ST_ALLOCATED) |-> (m_tdata[FW+2:FW] == 3'b000))
		else $error("page flags set on a result that is not an allocation");
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (CW'(scan_idx_q) < words_c))
		else $error("scan beyond the searched words");
	a_alloc_sets_one_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && mem_we) |-> ($countones(mem_wd) == $countones(rd_q) + 1))
		else $error("allocation write does not set exactly one bit");
`endif
endmodule
`default_nettype wire

// File: tb/sv/bfa_grant_checker.sv
// Checker for the frame allocator: mirrors the frame bitmap, predicts each result and compares.
`default_nettype none
module bfa_grant_checker
	import bfa_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_W-1:0]      cfg_wdata,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic                  s_tuser,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [OUT_DATA_W-1:0] m_tdata,
	input  wire logic [STATUS_W-1:0]   m_tuser,
	output int                         outstanding,
	output int                         failures
);
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FRAME_W-1:0]  frame;
		logic                present;
		logic                writable;
		logic                user_page;
	} page_result_t;

	logic [WORD_BITS-1:0] frame_map [MAX_FRAMES_DEF/WORD_BITS];
	logic [CFG_W-1:0]     managed_frames;
	page_result_t         expected_grants [$];
	int                   errs;

	// applies one request to the mirrored bitmap and returns the result it should give
	function automatic page_result_t grant_or_release(input logic op,
			input logic [FRAME_W-1:0] frame, input logic kern, input logic wr);
		page_result_t r;
		int limit;
		int span;
		r = '0;
		if (op == OP_ALLOC) begin
			if (frame != '0) begin
				r.status = ST_HELD;
				r.frame = frame;
				return r;
			end
			limit = int'(managed_frames);
			if (limit > MAX_FRAMES_DEF) begin
				limit = MAX_FRAMES_DEF;
			end
			span = limit / WORD_BITS;
			for (int w = 0; w < span; w++) begin
				for (int b = 0; b < WORD_BITS; b++) begin
					if (!frame_map[w][b]) begin
						frame_map[w][b] = 1'b1;
						r.status = ST_ALLOCATED;
						r.frame = FRAME_W'(w * WORD_BITS + b);
						r.present = 1'b1;
						r.writable = wr;
						r.user_page = !kern;
						return r;
					end
				end
			end
			r.status = ST_FULL;
			r.frame = frame;
			return r;
		end
		if (frame == '0) begin
			r.status = ST_NOTHING;
			return r;
		end
		frame_map[frame / WORD_BITS][frame % WORD_BITS] = 1'b0;
		r.status = ST_FREED;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		page_result_t got;
		page_result_t want;
		if (!arst_n) begin
			foreach (frame_map[i]) begin
				frame_map[i] = '0;
			end
			managed_frames = CFG_W'(FRAME_COUNT_RST);
			expected_grants.delete();
			errs = 0;
			outstanding <= 0;
			failures <= 0;
		end else begin
			if (cfg_we) begin
				managed_frames = cfg_wdata;
			end
			if (s_tvalid && s_tready) begin
				expected_grants.push_back(grant_or_release(s_tuser, s_tdata[FRAME_W-1:0],
					s_tdata[FRAME_W], s_tdata[FRAME_W+1]));
			end
			if (m_tvalid && m_tready) begin
				got.status = m_tuser;
				got.frame = m_tdata[FRAME_W-1:0];
				got.present = m_tdata[FRAME_W];
				got.writable = m_tdata[FRAME_W+1];
				got.user_page = m_tdata[FRAME_W+2];
				if (expected_grants.size() == 0) begin
					errs++;
					if (errs <= 10) begin
						$display("%0t: unexpected item status=%0d frame=%0d", $realtime,
							got.status, got.frame);
					end
				end else begin
					want = expected_grants.pop_front();
					if (got.status !== want.status || got.frame !== want.frame ||
							got.present !== want.present || got.writable !== want.writable ||
							got.user_page !== want.user_page) begin
						errs++;
						if (errs <= 10) begin
							$display("%0t: mismatch expected st=%0d fr=%0d p=%0b w=%0b u=%0b",
								$realtime, want.status, want.frame, want.present,
								want.writable, want.user_page);
							$display("%0t:          actual   st=%0d fr=%0d p=%0b w=%0b u=%0b",
								$realtime, got.status, got.frame, got.present,
								got.writable, got.user_page);
						end
					end
				end
			end
			outstanding <= expected_grants.size();
			failures <= errs;
		end
	end
endmodule
`default_nettype wire

// File: tb/sv/bitmap_frame_allocator_tb.sv
// Testbench top for the frame allocator: clock, reset, request and stall stimulus, verdict.
`default_nettype none
module bitmap_frame_allocator_tb;
	import bfa_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_W-1:0]      cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = OP_ALLOC;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]   m_tuser;
	int                    outstanding;
	int                    failures;
	logic                  calm = 1'b0;
	logic [CFG_W-1:0]      cur_count = CFG_W'(FRAME_COUNT_RST);

	bitmap_frame_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	bfa_grant_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.outstanding (outstanding),
		.failures    (failures)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#8000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			m_tready <= calm || ($urandom_range(99) >= 24);
		end
	end

	task automatic send_request(input logic op, input logic [FRAME_W-1:0] frame,
			input logic kern, input logic wr);
		while (!calm && $urandom_range(99) < 24) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {2'b00, wr, kern, frame};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic await_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_frame_count(input logic [CFG_W-1:0] value);
		await_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		cur_count = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [CFG_W-1:0] phase_counts [10];
		int hi;
		int pick;
		phase_counts = '{13'd64, 13'd33, 13'd4096, 13'd0, 13'd100, 13'd8191, 13'd40,
			13'd160, 13'd32, 13'd4096};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: first fit, held pages, frame zero, stray frees
		send_request(OP_ALLOC, 12'd0, 1'b0, 1'b1);
		send_request(OP_ALLOC, 12'd0, 1'b1, 1'b0);
		send_request(OP_ALLOC, 12'd0, 1'b1, 1'b1);
		send_request(OP_ALLOC, 12'd4095, 1'b1, 1'b1);
		send_request(OP_ALLOC, 12'hAAA, 1'b0, 1'b0);
		send_request(OP_ALLOC, 12'h555, 1'b1, 1'b0);
		send_request(OP_FREE, 12'd0, 1'b1, 1'b1);
		send_request(OP_FREE, 12'd1, 1'b0, 1'b0);
		send_request(OP_ALLOC, 12'd0, 1'b0, 1'b0);
		send_request(OP_FREE, 12'd4095, 1'b1, 1'b0);
		send_request(OP_FREE, 12'd2, 1'b0, 1'b1);
		send_request(OP_FREE, 12'd2, 1'b0, 1'b1);
		send_request(OP_ALLOC, 12'd0, 1'b1, 1'b1);
		await_idle();
		set_frame_count(13'd0);
		send_request(OP_ALLOC, 12'd0, 1'b0, 1'b1);
		send_request(OP_ALLOC, 12'd7, 1'b0, 1'b1);
		set_frame_count(13'd31);
		send_request(OP_ALLOC, 12'd0, 1'b1, 1'b1);
		set_frame_count(13'd32);
		send_request(OP_ALLOC, 12'd0, 1'b0, 1'b1);
		set_frame_count(13'd8191);
		send_request(OP_ALLOC, 12'd0, 1'b1, 1'b0);
		send_request(OP_FREE, 12'd3, 1'b0, 1'b0);
		send_request(OP_ALLOC, 12'd0, 1'b0, 1'b1);

		foreach (phase_counts[p]) begin
			set_frame_count(phase_counts[p]);
			calm = (p == 2);
			hi = (cur_count > 512) ? 511 : ((cur_count < 32) ? 31 : int'(cur_count) - 1);
			repeat (80) begin
				pick = $urandom_range(99);
				if (pick < 55) begin
					send_request(OP_ALLOC, 12'd0, 1'($urandom_range(1)),
						1'($urandom_range(1)));
				end else if (pick < 65) begin
					send_request(OP_ALLOC, FRAME_W'($urandom_range(4095, 1)),
						1'($urandom_range(1)), 1'($urandom_range(1)));
				end else if (pick < 92) begin
					send_request(OP_FREE, FRAME_W'($urandom_range(hi, 1)),
						1'($urandom_range(1)), 1'($urandom_range(1)));
				end else begin
					send_request(OP_FREE, FRAME_W'($urandom_range(4095)),
						1'($urandom_range(1)), 1'($urandom_range(1)));
				end
			end
		end
		calm = 1'b0;

		await_idle();
		repeat (200) @(posedge clk);
		if (failures == 0 && outstanding == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
`default_nettype wire

// File: filelist.f
src/bfa_pkg.sv
src/bitmap_frame_allocator.sv
tb/sv/bfa_grant_checker.sv
tb/sv/bitmap_frame_allocator_tb.sv
